// ----- rtl/tea_pkg.sv -----
// Shared constants, types and the round mixing function of the TEA block cipher.
package tea_pkg;

    localparam int NUM_CELLS = 32;
    localparam int LATENCY = 2 * NUM_CELLS + 1;
    localparam int ROUND_W = 6;
    localparam int CFG_INDEX_W = 3;

    localparam logic [31:0] TEA_DELTA = 32'h9e37_79b9;
    localparam logic [31:0] TEA_SHORT_SUM = 32'he377_9b90;
    localparam logic [31:0] TEA_LONG_SUM = 32'hc6ef_3720;
    localparam logic [ROUND_W-1:0] SHORT_ROUNDS = ROUND_W'(16);
    localparam logic [ROUND_W-1:0] LONG_ROUNDS = ROUND_W'(32);

    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD_0 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD_1 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD_2 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD_3 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_MODE = 3'd4;

    typedef struct packed {
        logic [31:0] word_0;
        logic [31:0] word_1;
        logic [31:0] word_2;
        logic [31:0] word_3;
    } key_t;

    typedef struct packed {
        logic               decrypt;
        logic [ROUND_W-1:0] rounds_left;
        logic [31:0]        sum;
        logic [31:0]        left;
        logic [31:0]        right;
    } stage_t;

    function automatic logic [31:0] tea_mix(
        input logic [31:0] x,
        input logic [31:0] sum,
        input logic [31:0] ka,
        input logic [31:0] kb
    );
        tea_mix = ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
    endfunction

endpackage

// ----- rtl/tea_round_cell.sv -----
// One TEA round as two registered half-round stages in the cell chain.
module tea_round_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  tea_pkg::key_t key,
    input  logic          in_valid,
    input  tea_pkg::stage_t in_stage,
    output logic          out_valid,
    output tea_pkg::stage_t out_stage
);
    import tea_pkg::*;

    logic   mid_valid_reg;
    stage_t mid_reg;
    stage_t mid_next;
    logic   out_valid_reg;
    stage_t out_reg;
    stage_t out_next;

    always_comb
    begin
        mid_next = in_stage;
        if (in_stage.rounds_left != '0)
        begin
            if (in_stage.decrypt)
            begin
                mid_next.right = in_stage.right
                    - tea_mix(in_stage.left, in_stage.sum, key.word_2, key.word_3);
            end
            else
            begin
                mid_next.left = in_stage.left
                    + tea_mix(in_stage.right, in_stage.sum, key.word_0, key.word_1);
            end
        end
    end

    always_comb
    begin
        out_next = mid_reg;
        if (mid_reg.rounds_left != '0)
        begin
            if (mid_reg.decrypt)
            begin
                out_next.left = mid_reg.left
                    - tea_mix(mid_reg.right, mid_reg.sum, key.word_0, key.word_1);
                out_next.sum = mid_reg.sum - TEA_DELTA;
            end
            else
            begin
                out_next.right = mid_reg.right
                    + tea_mix(mid_reg.left, mid_reg.sum, key.word_2, key.word_3);
                out_next.sum = mid_reg.sum + TEA_DELTA;
            end
            out_next.rounds_left = mid_reg.rounds_left - ROUND_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mid_valid_reg <= in_valid;
            out_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_reg <= mid_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_stage = out_reg;

endmodule

// ----- rtl/tea_block_cipher.sv -----
// Top level of the pipelined TEA block cipher with its configuration registers.
// An item is taken at a rising clock edge where start is high and busy is low.
// Busy is always low: the block takes a new item in every cycle.
// Operation selects encryption or decryption of block_left and block_right.
// The key words and long_mode are written through cfg_write, cfg_index and
// cfg_data; writes to unknown indexes are dropped. The user must write them
// only while no item is in flight; the block itself does not enforce this.
// Every item passes an input stage and 32 round cells of two half-round stages.
// With 16 rounds the last 16 cells pass the item through unchanged.
// The result appears on result_left and result_right for one cycle with done
// high, once the input stage and all round cells have registered it, in order
// of arrival.
// The receiver cannot stall, so the pipeline never holds and never drops items.
// Reset empties the pipeline, clears the key words and selects 32 rounds.
module tea_block_cipher (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [tea_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_data,
    input  logic                            start,
    output logic                            busy,
    input  logic                            operation,
    input  logic [31:0]                     block_left,
    input  logic [31:0]                     block_right,
    output logic                            done,
    output logic [31:0]                     result_left,
    output logic [31:0]                     result_right
);
    import tea_pkg::*;

    key_t   key_reg;
    logic   long_mode_reg;
    logic   accept;
    logic   valid_chain [NUM_CELLS+1];
    stage_t stage_chain [NUM_CELLS+1];
    logic   load_valid_reg;
    stage_t load_reg;
    stage_t load_next;

    assign busy = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
            long_mode_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_KEY_WORD_0: key_reg.word_0 <= cfg_data;
                CFG_KEY_WORD_1: key_reg.word_1 <= cfg_data;
                CFG_KEY_WORD_2: key_reg.word_2 <= cfg_data;
                CFG_KEY_WORD_3: key_reg.word_3 <= cfg_data;
                CFG_LONG_MODE: long_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        load_next.decrypt = operation;
        load_next.rounds_left = long_mode_reg ? LONG_ROUNDS : SHORT_ROUNDS;
        load_next.left = block_left;
        load_next.right = block_right;
        if (operation)
        begin
            load_next.sum = long_mode_reg ? TEA_LONG_SUM : TEA_SHORT_SUM;
        end
        else
        begin
            load_next.sum = TEA_DELTA;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_valid_reg <= 1'b0;
        end
        else
        begin
            load_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            load_reg <= load_next;
        end
    end

    assign valid_chain[0] = load_valid_reg;
    assign stage_chain[0] = load_reg;

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        tea_round_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .key       (key_reg),
            .in_valid  (valid_chain[i]),
            .in_stage  (stage_chain[i]),
            .out_valid (valid_chain[i+1]),
            .out_stage (stage_chain[i+1])
        );
    end

    assign done = valid_chain[NUM_CELLS];
    assign result_left = stage_chain[NUM_CELLS].left;
    assign result_right = stage_chain[NUM_CELLS].right;

    // Every accepted item leaves after a fixed latency.
    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted item did not leave after the pipeline latency");

    // Nothing leaves the chain that was not accepted one latency earlier.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("done without an item accepted one latency earlier");

    // An item that leaves the chain has run all of its rounds.
    a_rounds_spent: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (stage_chain[NUM_CELLS].rounds_left == '0))
        else $error("item left the chain with rounds still to run");

    // The input stage loads the round count that long_mode selected.
    a_load_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ((load_reg.rounds_left == LONG_ROUNDS) == $past(long_mode_reg)))
        else $error("input stage loaded the wrong round count");

endmodule

// ----- bench/tea_block_cipher_tb.sv -----
// Self-checking testbench of the TEA block cipher: directed and random items against a predictor.
module tea_block_cipher_tb;

    localparam int PIPE_DEPTH = 65;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 250;
    localparam int PHASES = 8;
    localparam int MAX_GAP = 10;
    localparam logic [31:0] ROUND_DELTA = 32'h9e37_79b9;
    localparam logic [31:0] SUM_AFTER_16 = 32'he377_9b90;
    localparam logic [31:0] SUM_AFTER_32 = 32'hc6ef_3720;
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef struct packed {
        logic [31:0] left;
        logic [31:0] right;
    } block_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [tea_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        start = 1'b0;
    logic        busy;
    logic        operation = 1'b0;
    logic [31:0] block_left = '0;
    logic [31:0] block_right = '0;
    logic        done;
    logic [31:0] result_left;
    logic [31:0] result_right;

    logic [31:0] key_copy [4];
    logic        long_copy;
    block_t      pending_blocks [$];
    block_t      oldest_block;
    int          error_count = 0;
    int          cycle_count = 0;

    tea_block_cipher dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .block_left   (block_left),
        .block_right  (block_right),
        .done         (done),
        .result_left  (result_left),
        .result_right (result_right)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tea_block_cipher_tb: errors");
            $finish;
        end
    end

    function automatic logic [31:0] round_mix(
        input logic [31:0] x,
        input logic [31:0] s,
        input logic [31:0] ka,
        input logic [31:0] kb
    );
        return ((x << 4) + ka) ^ (x + s) ^ ((x >> 5) + kb);
    endfunction

    function automatic block_t tea_transform(
        input logic        decrypt,
        input logic [31:0] l,
        input logic [31:0] r
    );
        logic [31:0] s;
        int          rounds;
        rounds = long_copy ? 32 : 16;
        if (!decrypt)
        begin
            s = '0;
            for (int i = 0; i < rounds; i++)
            begin
                s = s + ROUND_DELTA;
                l = l + round_mix(r, s, key_copy[0], key_copy[1]);
                r = r + round_mix(l, s, key_copy[2], key_copy[3]);
            end
        end
        else
        begin
            s = long_copy ? SUM_AFTER_32 : SUM_AFTER_16;
            for (int i = 0; i < rounds; i++)
            begin
                r = r - round_mix(l, s, key_copy[2], key_copy[3]);
                l = l - round_mix(r, s, key_copy[0], key_copy[1]);
                s = s - ROUND_DELTA;
            end
        end
        return '{left: l, right: r};
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %08h expected %08h", cycle_count, what, got,
                 want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_blocks.size() == 0)
                report_mismatch("result with no item outstanding", result_left, result_right);
            else
            begin
                oldest_block = pending_blocks.pop_front();
                if (result_left !== oldest_block.left)
                    report_mismatch("result_left", result_left, oldest_block.left);
                if (result_right !== oldest_block.right)
                    report_mismatch("result_right", result_right, oldest_block.right);
            end
        end
    end

    task automatic write_reg(input logic [tea_pkg::CFG_INDEX_W-1:0] index,
                             input logic [31:0] data);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (index)
            tea_pkg::CFG_KEY_WORD_0: key_copy[0] = data;
            tea_pkg::CFG_KEY_WORD_1: key_copy[1] = data;
            tea_pkg::CFG_KEY_WORD_2: key_copy[2] = data;
            tea_pkg::CFG_KEY_WORD_3: key_copy[3] = data;
            tea_pkg::CFG_LONG_MODE: long_copy = data[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_key(input logic [31:0] k0, input logic [31:0] k1,
                             input logic [31:0] k2, input logic [31:0] k3);
        write_reg(tea_pkg::CFG_KEY_WORD_0, k0);
        write_reg(tea_pkg::CFG_KEY_WORD_1, k1);
        write_reg(tea_pkg::CFG_KEY_WORD_2, k2);
        write_reg(tea_pkg::CFG_KEY_WORD_3, k3);
    endtask

    task automatic send_block(input logic op, input logic [31:0] l, input logic [31:0] r,
                              input bit idle);
        start <= 1'b1;
        operation <= op;
        block_left <= l;
        block_right <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_blocks.push_back(tea_transform(op, l, r));
        if (idle && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            operation <= 1'($urandom_range(0, 1));
            block_left <= $urandom;
            block_right <= $urandom;
            repeat ($urandom_range(1, MAX_GAP))
                @(posedge clk);
        end
    endtask

    task automatic wait_for_results(input int settle);
        start <= 1'b0;
        @(posedge clk);
        while (pending_blocks.size() != 0)
            @(posedge clk);
        repeat (settle)
            @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        send_block(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_block(OP_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
        send_block(OP_DECRYPT, 32'h0000_0000, 32'h0000_0000, 1'b1);
        send_block(OP_DECRYPT, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
        send_block(OP_ENCRYPT, 32'h8000_0000, 32'h0000_0001, 1'b1);
        send_block(OP_DECRYPT, 32'h0000_0001, 32'h8000_0000, 1'b0);
        wait_for_results(2);
    endtask

    task automatic test_key_extremes();
        write_key(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        write_reg(tea_pkg::CFG_LONG_MODE, 32'h0000_0001);
        send_block(OP_ENCRYPT, 32'h0000_0000, 32'hffff_ffff, 1'b0);
        send_block(OP_DECRYPT, 32'hffff_ffff, 32'h0000_0000, 1'b0);
        wait_for_results(2);
        write_reg(tea_pkg::CFG_LONG_MODE, 32'hffff_fffe);
        send_block(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000, 1'b1);
        send_block(OP_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
        send_block(OP_DECRYPT, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_block(OP_DECRYPT, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
        wait_for_results(2);
    endtask

    task automatic test_unused_indexes();
        write_key($urandom, $urandom, $urandom, $urandom);
        for (int i = int'(tea_pkg::CFG_LONG_MODE) + 1; i < (1 << tea_pkg::CFG_INDEX_W); i++)
            write_reg(i[tea_pkg::CFG_INDEX_W-1:0], $urandom);
        send_block(OP_ENCRYPT, $urandom, $urandom, 1'b0);
        send_block(OP_DECRYPT, $urandom, $urandom, 1'b0);
        wait_for_results(2);
    endtask

    task automatic test_round_trip();
        block_t plain;
        block_t cipher;
        for (int mode = 0; mode < 2; mode++)
        begin
            write_key($urandom, $urandom, $urandom, $urandom);
            write_reg(tea_pkg::CFG_LONG_MODE, {31'($urandom), mode[0]});
            for (int i = 0; i < 2; i++)
            begin
                plain = {pick_word(), pick_word()};
                cipher = tea_transform(OP_ENCRYPT, plain.left, plain.right);
                send_block(OP_ENCRYPT, plain.left, plain.right, 1'b1);
                send_block(OP_DECRYPT, cipher.left, cipher.right, 1'b0);
            end
            wait_for_results(2);
        end
    endtask

    task automatic test_random_items();
        bit idle;
        int extra_index;
        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
                write_key('0, '0, '0, '0);
            else if (p == 1)
                write_key('1, '1, '1, '1);
            else
                write_key(pick_word(), pick_word(), pick_word(), pick_word());
            write_reg(tea_pkg::CFG_LONG_MODE, {31'($urandom), p[0]});
            extra_index = $urandom_range(int'(tea_pkg::CFG_LONG_MODE) + 1,
                                         (1 << tea_pkg::CFG_INDEX_W) - 1);
            write_reg(extra_index[tea_pkg::CFG_INDEX_W-1:0], $urandom);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                idle = (p < PHASES - 1) && ((i / 40) % 2 == 0);
                send_block(1'($urandom_range(0, 1)), pick_word(), pick_word(), idle);
            end
            wait_for_results(2);
        end
    endtask

    initial
    begin
        for (int i = 0; i < 4; i++)
            key_copy[i] = '0;
        long_copy = 1'b1;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_key_extremes();
        test_unused_indexes();
        test_round_trip();
        test_random_items();
        wait_for_results(PIPE_DEPTH + 10);
        if (error_count == 0)
            $display("tea_block_cipher_tb: clean");
        else
            $display("tea_block_cipher_tb: errors");
        $finish;
    end

endmodule
